FILE: hdl/smac_pkg.sv
// Shared types, constants and helper functions for the stereo mix accumulator.
`default_nettype none

package smac_pkg;

    localparam int SLOT_W      = 12;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int VOL_W       = 16;
    localparam int RAW_W       = 32;
    localparam int SUM_W       = 32;
    localparam int OUT_W       = 16;
    localparam int RING_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OBUF_DEPTH  = 2;
    localparam int OCNT_W      = $clog2(OBUF_DEPTH + 1);
    localparam int SHIFT_W     = SUM_W - 8;

    localparam logic signed [OUT_W-1:0] CLAMP_HI   = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] CLAMP_LO   = -16'sd32768;
    localparam logic [7:0]              OFFSET_BIN = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEREO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_EIGHT_BIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_INDEX_MASK = 2'd3;

    typedef enum logic [1:0] {
        MODE_MIX   = 2'd0,
        MODE_RAW   = 2'd1,
        MODE_DRAIN = 2'd2
    } mode_t;

    typedef struct packed {
        logic [GAIN_W-1:0] master_volume;
        logic              out_stereo;
        logic              out_eight_bit;
        logic [RING_W-1:0] ring_index_mask;
    } cfg_t;

    typedef struct packed {
        mode_t                      mode;
        logic [SLOT_W-1:0]          slot;
        logic [SLOT_W-1:0]          quot;
        logic signed [SAMPLE_W-1:0] sample;
        logic [VOL_W-1:0]           left_vol;
        logic [VOL_W-1:0]           right_vol;
        logic signed [RAW_W-1:0]    raw_left;
        logic signed [RAW_W-1:0]    raw_right;
    } cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] right;
        logic signed [SUM_W-1:0] left;
    } sum_pair_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [OCNT_W-1:0] count;
        result_t           second;
        result_t           first;
    } push_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_add = s[SUM_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] drain_value(
        input logic signed [SUM_W-1:0] sum,
        input logic                    eight_bit
    );
        logic signed [SHIFT_W-1:0] shifted;
        logic signed [OUT_W-1:0]   clamped;
        logic [7:0]                offset_val;
        shifted = sum[SUM_W-1:8];
        if (shifted > SHIFT_W'(CLAMP_HI))
            clamped = CLAMP_HI;
        else if (shifted < SHIFT_W'(CLAMP_LO))
            clamped = CLAMP_LO;
        else
            clamped = shifted[OUT_W-1:0];
        // top byte plus 128, wrapping in eight bits
        offset_val = clamped[OUT_W-1:8] + OFFSET_BIN;
        if (eight_bit)
            drain_value = OUT_W'(offset_val);
        else
            drain_value = clamped;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/smac_front.sv
// Front end: accepts items, drops ignored modes, precomputes volumes and slot quotient.
`default_nettype none

module smac_front #(
    parameter int MIX_DEPTH = 4096
) (
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [smac_pkg::SLOT_W-1:0]          slot,
    input  logic signed [smac_pkg::SAMPLE_W-1:0] sample,
    input  logic [smac_pkg::GAIN_W-1:0]          left_gain,
    input  logic [smac_pkg::GAIN_W-1:0]          right_gain,
    input  logic signed [smac_pkg::RAW_W-1:0]    raw_left,
    input  logic signed [smac_pkg::RAW_W-1:0]    raw_right,
    input  logic [smac_pkg::GAIN_W-1:0]          master_volume,
    input  logic                                 back_ready,
    input  logic                                 q_full,
    output logic                                 q_push,
    output smac_pkg::cmd_t                       q_cmd
);
    import smac_pkg::*;

    localparam int IDX_W = $clog2(MIX_DEPTH);

    logic              known_mode;
    logic [SLOT_W-1:0] quot;

    generate
        if (MIX_DEPTH >= (1 << SLOT_W)) begin : g_no_wrap
            assign quot = '0;
        end else begin : g_wrap
            // floor(slot / MIX_DEPTH) by reciprocal multiply, exact for every slot code
            localparam int          K      = SLOT_W + IDX_W;
            localparam int          M_W    = SLOT_W + 2;
            localparam int          PROD_W = SLOT_W + M_W;
            localparam logic [63:0] RECIP  =
                ((64'd1 << K) + 64'(MIX_DEPTH) - 64'd1) / 64'(MIX_DEPTH);
            logic [PROD_W-1:0] recip_prod;
            assign recip_prod = PROD_W'(slot) * PROD_W'(RECIP[M_W-1:0]);
            assign quot       = SLOT_W'(recip_prod >> K);
        end
    endgenerate

    assign known_mode = (mode == MODE_MIX) || (mode == MODE_RAW) || (mode == MODE_DRAIN);
    assign in_ready   = back_ready && !q_full;
    assign q_push     = in_valid && in_ready && known_mode;

    always_comb
    begin
        q_cmd.mode      = mode_t'(mode);
        q_cmd.slot      = slot;
        q_cmd.quot      = quot;
        q_cmd.sample    = sample;
        q_cmd.left_vol  = VOL_W'(left_gain) * VOL_W'(master_volume);
        q_cmd.right_vol = VOL_W'(right_gain) * VOL_W'(master_volume);
        q_cmd.raw_left  = raw_left;
        q_cmd.raw_right = raw_right;
    end

endmodule

`default_nettype wire

FILE: hdl/smac_queue.sv
// Short command queue between the front end and the accumulate engine.
`default_nettype none

module smac_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smac_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output smac_pkg::cmd_t cmd_out
);
    import smac_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

FILE: hdl/smac_back.sv
// Accumulate engine: slot memory, clearing pass, saturating add and drain.
`default_nettype none

module smac_back #(
    parameter int MIX_DEPTH = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  smac_pkg::cmd_t                 q_cmd,
    output logic                           q_pop,
    input  smac_pkg::cfg_t                 cfg,
    input  logic [smac_pkg::OCNT_W-1:0]    out_free,
    output smac_pkg::push_t                push,
    output logic                           ready
);
    import smac_pkg::*;

    localparam int IDX_W = $clog2(MIX_DEPTH);
    localparam int MUL_W = SAMPLE_W + VOL_W + 1;

    sum_pair_t store_mem [MIX_DEPTH];

    logic [IDX_W-1:0]        idx0;
    logic signed [MUL_W-1:0] prod_l, prod_r;
    logic signed [SUM_W-1:0] add_l, add_r;

    logic                    b1_valid_reg, b1_valid_next;
    mode_t                   b1_mode_reg;
    logic [IDX_W-1:0]        b1_idx_reg;
    logic signed [SUM_W-1:0] b1_add_l_reg, b1_add_r_reg;
    sum_pair_t               rd_data_reg;

    logic                    fwd_valid_reg;
    logic [IDX_W-1:0]        fwd_idx_reg;
    sum_pair_t               fwd_data_reg;

    logic                    clr_active_reg, clr_active_next;
    logic [IDX_W-1:0]        clr_addr_reg, clr_addr_next;

    sum_pair_t               old_pair, new_pair, wdata;
    logic                    b1_done, adv, we;
    logic [IDX_W-1:0]        waddr;

    generate
        if (MIX_DEPTH >= (1 << SLOT_W)) begin : g_no_wrap
            assign idx0 = IDX_W'(q_cmd.slot);
        end else begin : g_wrap
            assign idx0 = IDX_W'(q_cmd.slot - SLOT_W'(q_cmd.quot * MIX_DEPTH));
        end
    endgenerate

    // stage 0: address, scaled sample products and per-mode addends
    always_comb
    begin
        prod_l = MUL_W'($signed(q_cmd.sample)) * MUL_W'($signed({1'b0, q_cmd.left_vol}));
        prod_r = MUL_W'($signed(q_cmd.sample)) * MUL_W'($signed({1'b0, q_cmd.right_vol}));
        add_l  = '0;
        add_r  = '0;
        unique case (q_cmd.mode)
            MODE_MIX:
            begin
                add_l = SUM_W'($signed(prod_l[MUL_W-1:8]));
                add_r = SUM_W'($signed(prod_r[MUL_W-1:8]));
            end
            MODE_RAW:
            begin
                add_l = q_cmd.raw_left;
                add_r = q_cmd.raw_right;
            end
            default: ;
        endcase
    end

    // stage 1: accumulate or drain, with bypass of the previous write
    always_comb
    begin
        old_pair = (fwd_valid_reg && fwd_idx_reg == b1_idx_reg) ? fwd_data_reg : rd_data_reg;
        new_pair = '0;
        push     = '0;
        b1_done  = 1'b1;
        unique case (b1_mode_reg)
            MODE_MIX, MODE_RAW:
            begin
                new_pair.left  = sat_add(old_pair.left, b1_add_l_reg);
                new_pair.right = sat_add(old_pair.right, b1_add_r_reg);
            end
            MODE_DRAIN:
            begin
                b1_done = cfg.out_stereo ? (out_free == OCNT_W'(OBUF_DEPTH))
                                         : (out_free != '0);
                push.first.value  = drain_value(old_pair.left, cfg.out_eight_bit);
                push.first.last   = !cfg.out_stereo;
                push.second.value = drain_value(old_pair.right, cfg.out_eight_bit);
                push.second.last  = 1'b1;
                if (b1_valid_reg && b1_done)
                    push.count = cfg.out_stereo ? OCNT_W'(2) : OCNT_W'(1);
            end
            default: ;
        endcase
    end

    assign adv   = b1_valid_reg && b1_done;
    assign q_pop = q_valid && !clr_active_reg && (!b1_valid_reg || b1_done);
    assign ready = !clr_active_reg;
    assign we    = clr_active_reg || adv;
    assign waddr = clr_active_reg ? clr_addr_reg : b1_idx_reg;
    assign wdata = clr_active_reg ? '0 : new_pair;

    always_comb
    begin
        b1_valid_next   = q_pop ? 1'b1 : (adv ? 1'b0 : b1_valid_reg);
        clr_active_next = clr_active_reg && (clr_addr_reg != IDX_W'(MIX_DEPTH - 1));
        clr_addr_next   = clr_active_reg ? clr_addr_reg + 1'b1 : clr_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            b1_valid_reg   <= b1_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            if (adv)
                fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_mode_reg  <= q_cmd.mode;
            b1_idx_reg   <= idx0;
            b1_add_l_reg <= add_l;
            b1_add_r_reg <= add_r;
        end
        if (adv)
        begin
            fwd_idx_reg  <= b1_idx_reg;
            fwd_data_reg <= new_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            store_mem[waddr] <= wdata;
        if (q_pop)
            rd_data_reg <= store_mem[idx0];
    end

endmodule

`default_nettype wire

FILE: hdl/smac_out.sv
// Output buffer: two-entry result queue with ring index stamping.
`default_nettype none

module smac_out (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smac_pkg::push_t                    push,
    input  smac_pkg::cfg_t                     cfg,
    output logic [smac_pkg::OCNT_W-1:0]        out_free,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [smac_pkg::OUT_W-1:0]  out_value,
    output logic [smac_pkg::RING_W-1:0]        ring_index,
    output logic                               last_of_slot
);
    import smac_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0]  value;
        logic [RING_W-1:0] ring;
        logic              last;
    } entry_t;

    entry_t            ent_reg [OBUF_DEPTH];
    entry_t            ent_next [OBUF_DEPTH];
    logic [OCNT_W-1:0] cnt_reg, cnt_next, cnt_shift;
    logic [RING_W-1:0] wp_reg, wp_next;
    logic              pop;
    entry_t            new0, new1;

    assign out_valid    = (cnt_reg != '0);
    assign out_value    = ent_reg[0].value;
    assign ring_index   = ent_reg[0].ring;
    assign last_of_slot = ent_reg[0].last;
    assign out_free     = OCNT_W'(OBUF_DEPTH) - cnt_reg;
    assign pop          = out_valid && out_ready;

    always_comb
    begin
        new0.value = push.first.value;
        new0.ring  = wp_reg & cfg.ring_index_mask;
        new0.last  = push.first.last;
        new1.value = push.second.value;
        new1.ring  = (wp_reg + 1'b1) & cfg.ring_index_mask;
        new1.last  = push.second.last;

        ent_next  = ent_reg;
        cnt_shift = cnt_reg - OCNT_W'(pop);
        if (pop)
            ent_next[0] = ent_reg[1];
        if (push.count != '0)
            ent_next[cnt_shift[0]] = new0;
        if (push.count == OCNT_W'(2))
            ent_next[1] = new1;
        cnt_next = cnt_shift + push.count;
        wp_next  = wp_reg + RING_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

FILE: hdl/stereo_mix_accumulate_and_clamp.sv
// Top level of the stereo mix accumulator.
// Input channel (in_valid/in_ready): one transaction per item; mode 0 mixes a
// scaled sample into a slot, mode 1 adds a raw stereo pair, mode 2 drains the
// slot, mode 3 is accepted and dropped. Output channel (out_valid/out_ready)
// carries drained values with their ring index; a stereo drain gives left then
// right. Config channel (cfg_valid/cfg_ready) is always ready; write only when
// the block is idle.
// Throughput: one item per cycle for mixes, raw adds and mono drains while no
// drain waits on the output buffer; a stereo drain waits for an empty output
// buffer, so it starts only once an earlier pair has left. The slot memory has
// one write and one read port, with a one-deep bypass so back-to-back hits on
// a slot are safe. A drain passes the command queue and stage-1 registers
// before its first result lands in the output buffer. Reset: config returns to
// defaults, then a clearing pass zeroes all MIX_DEPTH slot memory entries, one
// per cycle, with in_ready held low. Output stall: results wait in a two-entry
// buffer, a four-entry command queue absorbs further input, then in_ready drops.
`default_nettype none

module stereo_mix_accumulate_and_clamp #(
    parameter int MIX_DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic [smac_pkg::SLOT_W-1:0]            slot,
    input  logic signed [smac_pkg::SAMPLE_W-1:0]   sample,
    input  logic [smac_pkg::GAIN_W-1:0]            left_gain,
    input  logic [smac_pkg::GAIN_W-1:0]            right_gain,
    input  logic signed [smac_pkg::RAW_W-1:0]      raw_left,
    input  logic signed [smac_pkg::RAW_W-1:0]      raw_right,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [smac_pkg::OUT_W-1:0]      out_value,
    output logic [smac_pkg::RING_W-1:0]            ring_index,
    output logic                                   last_of_slot,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [smac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [smac_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import smac_pkg::*;

    cfg_t              cfg_reg;
    logic              back_ready;
    logic              q_full, q_push, q_pop, q_valid;
    cmd_t              q_in, q_out;
    push_t             push;
    logic [OCNT_W-1:0] out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_volume   <= 8'd255;
            cfg_reg.out_stereo      <= 1'b1;
            cfg_reg.out_eight_bit   <= 1'b0;
            cfg_reg.ring_index_mask <= 16'hffff;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MASTER_VOLUME:   cfg_reg.master_volume   <= cfg_data[GAIN_W-1:0];
                CFG_OUT_STEREO:      cfg_reg.out_stereo      <= cfg_data[0];
                CFG_OUT_EIGHT_BIT:   cfg_reg.out_eight_bit   <= cfg_data[0];
                CFG_RING_INDEX_MASK: cfg_reg.ring_index_mask <= cfg_data[RING_W-1:0];
                default: ;
            endcase
        end
    end

    smac_front #(
        .MIX_DEPTH(MIX_DEPTH)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .slot          (slot),
        .sample        (sample),
        .left_gain     (left_gain),
        .right_gain    (right_gain),
        .raw_left      (raw_left),
        .raw_right     (raw_right),
        .master_volume (cfg_reg.master_volume),
        .back_ready    (back_ready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_in)
    );

    smac_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (q_out)
    );

    smac_back #(
        .MIX_DEPTH(MIX_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_out),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .push     (push),
        .ready    (back_ready)
    );

    smac_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .cfg          (cfg_reg),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .ring_index   (ring_index),
        .last_of_slot (last_of_slot)
    );

`ifndef SYNTHESIS
    a_no_input_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) in_ready |-> back_ready
    ) else $error("input accepted during memory clearing pass");

    a_push_fits_buffer: assert property (
        @(posedge clk) disable iff (!rst_n) push.count <= out_free
    ) else $error("drain results overflow output buffer");

    a_right_follows_left: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_slot |=> out_valid
    ) else $error("right value of stereo drain not ready after left");
`endif

endmodule

`default_nettype wire

FILE: verif/stereo_mix_accumulate_and_clamp_tb.sv
// Self-checking testbench for the stereo mix accumulator: directed, random and back-pressure tests.
`timescale 1ns / 1ps

module stereo_mix_accumulate_and_clamp_tb;
    import smac_pkg::*;

    localparam int         MIX_DEPTH     = 4096;
    localparam logic [1:0] MODE_IGNORED  = 2'd3;
    localparam int         IDLE_PCT      = 18;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         MAX_PRINTS    = 50;

    typedef struct {
        logic [1:0]                 mode;
        logic [SLOT_W-1:0]          slot;
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          left_gain;
        logic [GAIN_W-1:0]          right_gain;
        logic signed [RAW_W-1:0]    raw_left;
        logic signed [RAW_W-1:0]    raw_right;
    } mix_txn_t;

    typedef struct {
        logic [OUT_W-1:0]  value;
        logic [RING_W-1:0] ring;
        logic              last;
    } drained_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [1:0]                 mode         = '0;
    logic [SLOT_W-1:0]          slot         = '0;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic [GAIN_W-1:0]          left_gain    = '0;
    logic [GAIN_W-1:0]          right_gain   = '0;
    logic signed [RAW_W-1:0]    raw_left     = '0;
    logic signed [RAW_W-1:0]    raw_right    = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [OUT_W-1:0]    out_value;
    logic [RING_W-1:0]          ring_index;
    logic                       last_of_slot;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;

    // mixer image
    int                left_sum  [MIX_DEPTH];
    int                right_sum [MIX_DEPTH];
    logic [RING_W-1:0] write_pos  = '0;
    logic [GAIN_W-1:0] cfg_master = 8'd255;
    logic              cfg_stereo = 1'b1;
    logic              cfg_eight  = 1'b0;
    logic [RING_W-1:0] cfg_mask   = 16'hffff;
    drained_t          pending_drains [$];

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int out_hold    = 0;

    int error_count  = 0;
    int items_sent   = 0;
    int drains_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    stereo_mix_accumulate_and_clamp #(
        .MIX_DEPTH (MIX_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .slot         (slot),
        .sample       (sample),
        .left_gain    (left_gain),
        .right_gain   (right_gain),
        .raw_left     (raw_left),
        .raw_right    (raw_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .ring_index   (ring_index),
        .last_of_slot (last_of_slot),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int sat_sum(input int acc, input longint addend);
        longint s;
        s = longint'(acc) + addend;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        else if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return int'(s);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_drain(input int sum);
        longint v;
        v = longint'(sum) >>> 8;
        if (v > 64'sd32767)
            v = 64'sd32767;
        else if (v < -64'sd32768)
            v = -64'sd32768;
        if (cfg_eight)
            v = (v >>> 8) + 128;
        return v[OUT_W-1:0];
    endfunction

    task automatic push_drained(input logic [OUT_W-1:0] value, input logic last);
        pending_drains.push_back('{value, write_pos & cfg_mask, last});
        write_pos++;
    endtask

    task automatic accumulate_and_drain(input mix_txn_t t);
        longint s;
        longint lv;
        longint rv;
        int     idx;
        idx = int'(t.slot) % MIX_DEPTH;
        case (t.mode)
            MODE_MIX:
            begin
                s  = t.sample;
                lv = t.left_gain;
                rv = t.right_gain;
                lv = lv * longint'(cfg_master);
                rv = rv * longint'(cfg_master);
                left_sum[idx]  = sat_sum(left_sum[idx], (s * lv) >>> 8);
                right_sum[idx] = sat_sum(right_sum[idx], (s * rv) >>> 8);
            end
            MODE_RAW:
            begin
                left_sum[idx]  = sat_sum(left_sum[idx], longint'(t.raw_left));
                right_sum[idx] = sat_sum(right_sum[idx], longint'(t.raw_right));
            end
            MODE_DRAIN:
            begin
                drains_sent++;
                if (cfg_stereo)
                begin
                    push_drained(clamp_drain(left_sum[idx]), 1'b0);
                    push_drained(clamp_drain(right_sum[idx]), 1'b1);
                end
                else
                    push_drained(clamp_drain(left_sum[idx]), 1'b1);
                left_sum[idx]  = 0;
                right_sum[idx] = 0;
            end
            default: ;
        endcase
    endtask

    function automatic mix_txn_t make_txn(
        input logic [1:0]                 m,
        input logic [SLOT_W-1:0]          s,
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [GAIN_W-1:0]          lg,
        input logic [GAIN_W-1:0]          rg,
        input logic signed [RAW_W-1:0]    rl,
        input logic signed [RAW_W-1:0]    rr
    );
        mix_txn_t t;
        t = '{m, s, smp, lg, rg, rl, rr};
        return t;
    endfunction

    function automatic logic signed [RAW_W-1:0] rand_raw();
        int v;
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return RAW_W'($urandom);
            default:
            begin
                v = $urandom_range(33554432);
                return v - 16777216;
            end
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic mix_txn_t random_txn(input logic [1:0] m, input logic [SLOT_W-1:0] s);
        mix_txn_t t;
        t.mode = m;
        t.slot = s;
        case ($urandom_range(7))
            0: t.sample = 16'sh7fff;
            1: t.sample = -16'sd32768;
            default: t.sample = SAMPLE_W'($urandom);
        endcase
        t.left_gain  = rand_gain();
        t.right_gain = rand_gain();
        t.raw_left   = rand_raw();
        t.raw_right  = rand_raw();
        return t;
    endfunction

    task automatic send_txn(input mix_txn_t t);
        @(negedge clk);
        while (in_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        mode       = t.mode;
        slot       = t.slot;
        sample     = t.sample;
        left_gain  = t.left_gain;
        right_gain = t.right_gain;
        raw_left   = t.raw_left;
        raw_right  = t.raw_right;
        do @(posedge clk); while (!in_ready);
        accumulate_and_drain(t);
        items_sent++;
    endtask

    task automatic wait_quiet;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drains.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MASTER_VOLUME:   cfg_master = data[GAIN_W-1:0];
            CFG_OUT_STEREO:      cfg_stereo = data[0];
            CFG_OUT_EIGHT_BIT:   cfg_eight  = data[0];
            CFG_RING_INDEX_MASK: cfg_mask   = data[RING_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // unused upper data bits carry noise
    task automatic set_config(
        input logic [GAIN_W-1:0] mv,
        input logic              st,
        input logic              eb,
        input logic [RING_W-1:0] mask
    );
        logic [CFG_DATA_W-1:0] d;
        wait_quiet();
        d = CFG_DATA_W'($urandom);
        d[GAIN_W-1:0] = mv;
        write_reg(CFG_MASTER_VOLUME, d);
        d = CFG_DATA_W'($urandom);
        d[0] = st;
        write_reg(CFG_OUT_STEREO, d);
        d = CFG_DATA_W'($urandom);
        d[0] = eb;
        write_reg(CFG_OUT_EIGHT_BIT, d);
        write_reg(CFG_RING_INDEX_MASK, mask);
    endtask

    initial
    begin : result_check
        drained_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (pending_drains.size() == 0)
                    report_error($sformatf("unexpected transaction value %h ring %h last %b",
                                           out_value, ring_index, last_of_slot));
                else
                begin
                    want = pending_drains.pop_front();
                    if (out_value !== want.value)
                        report_error($sformatf("out_value %h, wanted %h", out_value, want.value));
                    if (ring_index !== want.ring)
                        report_error($sformatf("ring_index %h, wanted %h", ring_index, want.ring));
                    if (last_of_slot !== want.last)
                        report_error($sformatf("last_of_slot %b, wanted %b",
                                               last_of_slot, want.last));
                end
            end
        end
    end

    initial
    begin : sink_ready
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
            begin
                out_ready = 1'b0;
                out_hold--;
            end
            else
                out_ready = !(out_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // reset config, stereo 16-bit
    task automatic test_reset_defaults;
        send_txn(make_txn(MODE_DRAIN, 12'd0, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_MIX, 12'd1, 16'sh7fff, 8'hff, 8'h00, 32'sd5, -32'sd5));
        send_txn(make_txn(MODE_MIX, 12'd1, -16'sd32768, 8'h00, 8'hff, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_DRAIN, 12'd1, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_RAW, 12'hfff, 16'sd0, 8'd0, 8'd0, 32'sh7fffffff, 32'sh80000000));
        send_txn(make_txn(MODE_RAW, 12'hfff, 16'sd0, 8'd0, 8'd0, 32'sh7fffffff, 32'sh80000000));
        send_txn(make_txn(MODE_DRAIN, 12'hfff, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        // ignored mode must leave the slot untouched
        send_txn(make_txn(MODE_IGNORED, 12'd2, 16'sh7fff, 8'hff, 8'hff,
                          32'sh00ffffff, 32'sh00ffffff));
        send_txn(make_txn(MODE_DRAIN, 12'd2, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_RAW, 12'd7, 16'sd0, 8'd0, 8'd0, 32'sh00012345, -32'sd1023));
        send_txn(make_txn(MODE_MIX, 12'd7, -16'sd1234, 8'd77, 8'd200, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_DRAIN, 12'd7, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
    endtask

    // mono, eight-bit, zero master volume, small ring masks
    task automatic test_output_formats;
        set_config(8'd255, 1'b0, 1'b0, 16'hffff);
        send_txn(make_txn(MODE_RAW, 12'd9, 16'sd0, 8'd0, 8'd0, 32'sh00400000, 32'sh7fffffff));
        send_txn(make_txn(MODE_DRAIN, 12'd9, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        set_config(8'd255, 1'b1, 1'b1, 16'h0007);
        // right sum went with the mono drain
        send_txn(make_txn(MODE_DRAIN, 12'd9, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_RAW, 12'd10, 16'sd0, 8'd0, 8'd0, -32'sd1, 32'sh007fff00));
        send_txn(make_txn(MODE_DRAIN, 12'd10, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_RAW, 12'd11, 16'sd0, 8'd0, 8'd0, 32'sh80000000, 32'sh7fffffff));
        send_txn(make_txn(MODE_DRAIN, 12'd11, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
        set_config(8'd0, 1'b1, 1'b0, 16'h0000);
        send_txn(make_txn(MODE_MIX, 12'd13, 16'sh7fff, 8'hff, 8'hff, 32'sd0, 32'sd0));
        send_txn(make_txn(MODE_DRAIN, 12'd13, 16'sd0, 8'd0, 8'd0, 32'sd0, 32'sd0));
    endtask

    task automatic run_random_phase(input int n_items);
        logic [SLOT_W-1:0] hot [8];
        logic [SLOT_W-1:0] s;
        mix_txn_t          t;
        int                sent;
        int                burst;
        foreach (hot[i])
            hot[i] = SLOT_W'($urandom);
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                t = random_txn(2'($urandom), SLOT_W'($urandom));
                send_txn(t);
                if (t.mode != MODE_IGNORED)
                    sent++;
            end
            else
            begin
                s = ($urandom_range(99) < 80) ? hot[$urandom_range(7)] : SLOT_W'($urandom);
                burst = $urandom_range(4);
                repeat (burst)
                begin
                    send_txn(random_txn($urandom_range(1) ? MODE_MIX : MODE_RAW, s));
                    sent++;
                end
                send_txn(random_txn(MODE_DRAIN, s));
                sent++;
            end
        end
    endtask

    task automatic test_random_configs;
        set_config(8'd255, 1'b1, 1'b0, 16'hffff);
        run_random_phase(200);
        set_config(8'h80, 1'b0, 1'b0, 16'h00ff);
        run_random_phase(200);
        set_config(GAIN_W'($urandom), 1'b1, 1'b1, 16'h0003);
        run_random_phase(200);
        set_config(8'd1, 1'b0, 1'b1, 16'h0000);
        run_random_phase(200);
        set_config(GAIN_W'($urandom), 1'b1, 1'b0, RING_W'((1 << $urandom_range(16)) - 1));
        // no idling on either side
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_random_phase(200);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // receiver holds off while input keeps coming; block fills and stalls
    task automatic test_back_pressure;
        set_config(GAIN_W'($urandom), 1'b1, 1'b0, 16'hffff);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        @(posedge clk);
        out_hold = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_txn(random_txn((i % 3 == 2) ? MODE_DRAIN : MODE_RAW, SLOT_W'(i / 3)));
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        wait_quiet();
    endtask

    initial
    begin : main_seq
        int guard;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_output_formats();
        test_random_configs();
        test_back_pressure();

        @(negedge clk);
        in_valid = 1'b0;
        guard = 0;
        while (pending_drains.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_drains.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_drains.size()));

        $display("Covered %0d input transactions, %0d of them drains, %0d results, %0d reg writes",
                 items_sent, drains_sent, results_seen, cfg_writes);
        $display("Mono/stereo, eight-bit, zero and full volume, ring masks 0..ffff, %0d-cycle hold",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
